// File: hw/rtl/vlcp_pkg.sv
// Shared types and constants for the variable-length code packer.
package vlcp_pkg;

  localparam int FUNC_W   = 2;
  localparam int SYMBOL_W = 8;
  localparam int CODE_W   = 15;
  localparam int LEN_W    = 4;
  localparam int BYTE_W   = 8;
  localparam int PEND_W   = 3;
  localparam int ACC_W    = 24;

  localparam logic [FUNC_W-1:0] FUNC_WRITE  = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_ENCODE = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_FLUSH  = 2'd2;

  typedef struct packed {
    logic valid;
    logic flush;
  } vlcp_ctl_t;

endpackage

// File: hw/rtl/vlcp_if.sv
// Valid/ready channel interfaces for the packer input and output.
interface vlcp_in_if;
  import vlcp_pkg::*;
  logic                valid;
  logic                ready;
  logic [FUNC_W-1:0]   func;
  logic [SYMBOL_W-1:0] symbol;
  logic [CODE_W-1:0]   code_bits;
  logic [LEN_W-1:0]    code_length;
  modport source (output valid, func, symbol, code_bits, code_length, input ready);
  modport sink   (input valid, func, symbol, code_bits, code_length, output ready);
endinterface

interface vlcp_out_if;
  import vlcp_pkg::*;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] out_byte;
  logic              last;
  modport source (output valid, out_byte, last, input ready);
  modport sink   (input valid, out_byte, last, output ready);
endinterface

// File: hw/rtl/vlcp_table.sv
// Code table memory with write-on-transfer and registered lookup stage.
module vlcp_table #(
  parameter int MAX_CODE_LENGTH = 15,
  parameter int SYMBOL_COUNT    = 256
) (
  input  logic                         clk,
  input  logic                         rst_n,
  vlcp_in_if.sink                      in_s,
  input  logic                         take,
  output vlcp_pkg::vlcp_ctl_t          ctl,
  output logic [MAX_CODE_LENGTH-1:0]   code,
  output logic [vlcp_pkg::LEN_W-1:0]   len
);
  import vlcp_pkg::*;

  localparam int CW = MAX_CODE_LENGTH;
  localparam int AW = (SYMBOL_COUNT > 1) ? $clog2(SYMBOL_COUNT) : 1;
  localparam int EW = CW + LEN_W;

  logic [EW-1:0] mem [SYMBOL_COUNT];
  logic [EW-1:0] rd_r;
  logic          s1_valid_r, s1_valid_nxt;
  logic          s1_flush_r;
  logic          s1_hit_r;

  logic          accept;
  logic          in_range;
  logic [AW-1:0] addr;
  logic [LEN_W-1:0] len_sat;
  logic [CW-1:0] code_masked;

  assign in_s.ready = !s1_valid_r || take;
  assign accept     = in_s.valid && in_s.ready;
  assign in_range   = {1'b0, in_s.symbol} < (SYMBOL_W + 1)'(SYMBOL_COUNT);
  assign addr       = in_s.symbol[AW-1:0];
  assign len_sat    = (in_s.code_length > LEN_W'(MAX_CODE_LENGTH)) ?
                      LEN_W'(MAX_CODE_LENGTH) : in_s.code_length;

  always_comb begin
    for (int i = 0; i < CW; i++) begin
      code_masked[i] = in_s.code_bits[i] && (LEN_W'(i) < len_sat);
    end
  end

  always_ff @(posedge clk) begin
    if (accept && in_s.func == FUNC_WRITE && in_range) begin
      mem[addr] <= {len_sat, code_masked};
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rd_r       <= mem[addr];
      s1_flush_r <= (in_s.func == FUNC_FLUSH);
      s1_hit_r   <= in_range;
    end
  end

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (accept) begin
      s1_valid_nxt = (in_s.func == FUNC_ENCODE) || (in_s.func == FUNC_FLUSH);
    end else if (take) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  assign ctl.valid = s1_valid_r;
  assign ctl.flush = s1_flush_r;
  assign code      = s1_hit_r ? rd_r[CW-1:0] : '0;
  assign len       = s1_hit_r ? rd_r[EW-1:CW] : '0;

endmodule

// File: hw/rtl/vlcp_packer.sv
// Bit cache, byte assembly and two-entry output buffer.
module vlcp_packer #(
  parameter int MAX_CODE_LENGTH = 15
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  vlcp_pkg::vlcp_ctl_t          ctl,
  input  logic [MAX_CODE_LENGTH-1:0]   code,
  input  logic [vlcp_pkg::LEN_W-1:0]   len,
  output logic                         take,
  vlcp_out_if.source                   out_m
);
  import vlcp_pkg::*;

  logic [PEND_W-1:0] pending_r, pending_nxt;
  logic [6:0]        cache_r, cache_nxt;
  logic [BYTE_W-1:0] byte0_r, byte0_nxt;
  logic [BYTE_W-1:0] byte1_r, byte1_nxt;
  logic              last0_r, last0_nxt;
  logic [1:0]        cnt_r, cnt_nxt;

  logic              pop;
  logic [ACC_W-1:0]  acc;
  logic [ACC_W-1:0]  shifted;
  logic [4:0]        total;
  logic [1:0]        nb;
  logic [PEND_W-1:0] newp;
  logic [6:0]        keep_mask;

  assign pop  = out_m.valid && out_m.ready;
  assign take = ctl.valid && ((cnt_r == 2'd0) || (cnt_r == 2'd1 && pop));

  assign acc       = ACC_W'(cache_r) | (ACC_W'(code) << pending_r);
  assign total     = 5'(pending_r) + 5'(len);
  assign nb        = total[4:3];
  assign newp      = total[2:0];
  assign shifted   = acc >> {nb, 3'b000};
  assign keep_mask = (7'd1 << newp) - 7'd1;

  always_comb begin
    pending_nxt = pending_r;
    cache_nxt   = cache_r;
    byte0_nxt   = byte0_r;
    byte1_nxt   = byte1_r;
    last0_nxt   = last0_r;
    cnt_nxt     = cnt_r;
    if (pop) begin
      byte0_nxt = byte1_r;
      last0_nxt = 1'b1;
      cnt_nxt   = cnt_r - 2'd1;
    end
    if (take) begin
      if (ctl.flush) begin
        byte0_nxt   = {1'b0, cache_r};
        last0_nxt   = 1'b1;
        cnt_nxt     = (pending_r != '0) ? 2'd1 : 2'd0;
        pending_nxt = '0;
        cache_nxt   = '0;
      end else begin
        byte0_nxt   = acc[7:0];
        byte1_nxt   = acc[15:8];
        last0_nxt   = (nb == 2'd1);
        cnt_nxt     = nb;
        pending_nxt = newp;
        cache_nxt   = shifted[6:0] & keep_mask;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r <= '0;
      cache_r   <= '0;
      cnt_r     <= 2'd0;
    end else begin
      pending_r <= pending_nxt;
      cache_r   <= cache_nxt;
      cnt_r     <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    byte0_r <= byte0_nxt;
    byte1_r <= byte1_nxt;
    last0_r <= last0_nxt;
  end

  assign out_m.valid    = (cnt_r != 2'd0);
  assign out_m.out_byte = byte0_r;
  assign out_m.last     = last0_r;

  logic [6:0] pend_mask;
  assign pend_mask = (7'd1 << pending_r) - 7'd1;

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r != 2'd3)
    else $error("output buffer count out of range");

  a_cache_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (cache_r & ~pend_mask) == 7'd0)
    else $error("bit cache holds bits above pending count");

  a_flush_clears: assert property (@(posedge clk) disable iff (!rst_n)
    take && ctl.flush |=> pending_r == '0 && cache_r == '0)
    else $error("flush left bits pending");

  a_two_bytes_last: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r == 2'd2 |-> !last0_r)
    else $error("first of two bytes marked last");

endmodule

// File: hw/rtl/variable_length_code_packer.sv
// Top level of the variable-length code packer.
// The first byte is offered after the table stage and the output buffer register it.
// Throughput: one input item per cycle while the output is ready and each item
// yields at most one byte; a two-byte item holds the output port, and so the input.
// Reset clears the cache, pending and buffer counts; the code table is not cleared.
module variable_length_code_packer #(
  parameter int MAX_CODE_LENGTH = 15,
  parameter int SYMBOL_COUNT    = 256
) (
  input  logic       clk,
  input  logic       rst_n,
  vlcp_in_if.sink    in_s,
  vlcp_out_if.source out_m
);
  import vlcp_pkg::*;

  vlcp_ctl_t                  ctl;
  logic                       take;
  logic [MAX_CODE_LENGTH-1:0] code;
  logic [LEN_W-1:0]           len;

  vlcp_table #(
    .MAX_CODE_LENGTH (MAX_CODE_LENGTH),
    .SYMBOL_COUNT    (SYMBOL_COUNT)
  ) u_table (
    .clk   (clk),
    .rst_n (rst_n),
    .in_s  (in_s),
    .take  (take),
    .ctl   (ctl),
    .code  (code),
    .len   (len)
  );

  vlcp_packer #(
    .MAX_CODE_LENGTH (MAX_CODE_LENGTH)
  ) u_packer (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (ctl),
    .code  (code),
    .len   (len),
    .take  (take),
    .out_m (out_m)
  );

endmodule
